/* rtl/plu_pkg.sv */
// ----------------------------------------------------------------------------
// plu_pkg
// Shared types, codes and helper functions for the palette lookup unit.
// ----------------------------------------------------------------------------
package plu_pkg;

    localparam int RAM_BYTES   = 64;
    localparam int RAM_WORDS   = RAM_BYTES / 2;
    localparam int BYTE_ADDR_W = $clog2(RAM_BYTES);
    localparam int WORD_ADDR_W = $clog2(RAM_WORDS);

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] SRC_BLANK = 2'd0;
    localparam logic [1:0] SRC_BG    = 2'd1;

    localparam logic [1:0] PORT_BG_SPEC  = 2'd0;
    localparam logic [1:0] PORT_BG_DATA  = 2'd1;
    localparam logic [1:0] PORT_OBJ_SPEC = 2'd2;
    localparam logic [1:0] PORT_OBJ_DATA = 2'd3;

    localparam logic [2:0] CFG_COLOR_MODE   = 3'd0;
    localparam logic [2:0] CFG_SHADE_OUTPUT = 3'd1;
    localparam logic [2:0] CFG_BG_MAP       = 3'd2;
    localparam logic [2:0] CFG_OBJ_MAP0     = 3'd3;
    localparam logic [2:0] CFG_OBJ_MAP1     = 3'd4;

    localparam int         SPEC_AUTO_INC  = 7;
    localparam logic [7:0] SPEC_READ_BITS = 8'h40;
    localparam logic [7:0] READ_BLOCKED   = 8'hFF;
    localparam logic [7:0] WHITE_LEVEL    = 8'hFF;

    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_WHITE,
        KIND_SHADE,
        KIND_RGB_BG,
        KIND_RGB_OBJ,
        KIND_BYTE_BG,
        KIND_BYTE_OBJ,
        KIND_LIT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] shade;
        logic       byte_hi;
        logic [7:0] lit;
    } item_ctl_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] pixel_source;
        logic [2:0] pixel_palette;
        logic [1:0] pixel_color;
        logic       first_frame_blank;
        logic [1:0] port_select;
        logic [7:0] write_data;
        logic       drawing;
    } req_t;

    typedef struct packed {
        logic       color_mode;
        logic       shade_output;
        logic [7:0] bg_shade_map;
        logic [7:0] obj_shade_map0;
        logic [7:0] obj_shade_map1;
    } cfg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    function automatic rgb_t shade_rgb(input logic [1:0] s);
        rgb_t c;
        case (s)
            2'd0:    c = '{blue: 8'd70,  green: 8'd203, red: 8'd175};
            2'd1:    c = '{blue: 8'd109, green: 8'd170, red: 8'd121};
            2'd2:    c = '{blue: 8'd95,  green: 8'd111, red: 8'd34};
            default: c = '{blue: 8'd85,  green: 8'd41,  red: 8'd8};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [7:0] spec_step(input logic [7:0] s);
        logic [5:0] idx;
        idx = s[5:0] + 6'd1;
        return s[SPEC_AUTO_INC] ? {2'b10, idx} : s;
    endfunction

endpackage

/* rtl/palette_lookup_rgb555_expand_unit.sv */
// ----------------------------------------------------------------------------
// palette_lookup_rgb555_expand_unit
// Palette lookup: pixels to 8-bit rgb, palette port reads and writes.
// ----------------------------------------------------------------------------
// pipeline: a request passes through the ram read register, then the result
//   register
// throughput: one request per cycle; a stalled output holds both stages, so
//   up to two requests wait inside before s_tready drops
// reset: rst_n clears config, spec registers, pipeline valids and ram valid
//   bits at once; no clearing pass, requests are taken right after reset
module palette_lookup_rgb555_expand_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_source[1:0], pixel_palette[4:2], pixel_color[6:5],
    // first_frame_blank[7], port_select[9:8], write_data[17:10], drawing[18]
    input  logic [23:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red[7:0], green[15:8], blue[23:16], read_data[31:24]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import plu_pkg::*;

    cfg_t                   cfg_reg;
    logic [7:0]             bg_spec_reg;
    logic [7:0]             bg_spec_next;
    logic [7:0]             obj_spec_reg;
    logic [7:0]             obj_spec_next;
    logic                   s1_vld_reg;
    item_ctl_t              s1_ctl_reg;
    logic                   out_vld_reg;
    logic [31:0]            out_data_reg;
    req_t                   req;
    item_ctl_t              ctl;
    logic [WORD_ADDR_W-1:0] rd_addr;
    logic                   in_acc;
    logic                   s1_move;
    logic                   bg_wr_en;
    logic                   obj_wr_en;
    logic [15:0]            bg_word;
    logic [15:0]            obj_word;
    rgb_t                   rgb;
    logic [7:0]             read_data;

    assign req.pixel_source      = s_tdata[1:0];
    assign req.pixel_palette     = s_tdata[4:2];
    assign req.pixel_color       = s_tdata[6:5];
    assign req.first_frame_blank = s_tdata[7];
    assign req.port_select       = s_tdata[9:8];
    assign req.write_data        = s_tdata[17:10];
    assign req.drawing           = s_tdata[18];
    assign req.req_type          = s_tuser;

    assign s1_move   = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !s1_vld_reg || s1_move;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign bg_wr_en  = in_acc && req.req_type == REQ_WRITE &&
                       req.port_select == PORT_BG_DATA && !req.drawing;
    assign obj_wr_en = in_acc && req.req_type == REQ_WRITE &&
                       req.port_select == PORT_OBJ_DATA && !req.drawing;

    plu_decode u_decode (
        .req      (req),
        .cfg      (cfg_reg),
        .bg_spec  (bg_spec_reg),
        .obj_spec (obj_spec_reg),
        .ctl      (ctl),
        .rd_addr  (rd_addr)
    );

    plu_color_ram u_bg_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bg_wr_en),
        .wr_addr (bg_spec_reg[BYTE_ADDR_W-1:0]),
        .wr_data (req.write_data),
        .rd_en   (in_acc),
        .rd_addr (rd_addr),
        .rd_data (bg_word)
    );

    plu_color_ram u_obj_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (obj_wr_en),
        .wr_addr (obj_spec_reg[BYTE_ADDR_W-1:0]),
        .wr_data (req.write_data),
        .rd_en   (in_acc),
        .rd_addr (rd_addr),
        .rd_data (obj_word)
    );

    plu_pixel_out u_pixel_out (
        .ctl       (s1_ctl_reg),
        .bg_word   (bg_word),
        .obj_word  (obj_word),
        .rgb       (rgb),
        .read_data (read_data)
    );

    always_comb
    begin
        bg_spec_next  = bg_spec_reg;
        obj_spec_next = obj_spec_reg;
        if (in_acc && req.req_type == REQ_WRITE)
        begin
            case (req.port_select)
                PORT_BG_SPEC:  bg_spec_next  = req.write_data;
                PORT_BG_DATA:  bg_spec_next  = spec_step(bg_spec_reg);
                PORT_OBJ_SPEC: obj_spec_next = req.write_data;
                default:       obj_spec_next = spec_step(obj_spec_reg);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            bg_spec_reg  <= '0;
            obj_spec_reg <= '0;
            s1_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            bg_spec_reg  <= bg_spec_next;
            obj_spec_reg <= obj_spec_next;
            if (s_tready)
            begin
                s1_vld_reg <= s_tvalid;
            end
            if (!out_vld_reg || m_tready)
            begin
                out_vld_reg <= s1_vld_reg;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_COLOR_MODE:   cfg_reg.color_mode     <= cfg_data[0];
                    CFG_SHADE_OUTPUT: cfg_reg.shade_output   <= cfg_data[0];
                    CFG_BG_MAP:       cfg_reg.bg_shade_map   <= cfg_data;
                    CFG_OBJ_MAP0:     cfg_reg.obj_shade_map0 <= cfg_data;
                    CFG_OBJ_MAP1:     cfg_reg.obj_shade_map1 <= cfg_data;
                    default:          cfg_reg                <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ctl_reg <= ctl;
        end
        if (s1_move)
        begin
            out_data_reg <= {read_data, rgb.blue, rgb.green, rgb.red};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !s1_move) |=> (s1_vld_reg && $stable(s1_ctl_reg)))
        else $error("stalled stage 1 request changed");

    a_bg_autoinc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req.req_type == REQ_WRITE && req.port_select == PORT_BG_DATA &&
         bg_spec_reg[SPEC_AUTO_INC]) |=> (bg_spec_reg[SPEC_AUTO_INC] && !bg_spec_reg[6]))
        else $error("bg spec auto-increment lost its mode bit");

    a_port_no_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && (s1_ctl_reg.kind == KIND_LIT || s1_ctl_reg.kind == KIND_BYTE_BG ||
                     s1_ctl_reg.kind == KIND_BYTE_OBJ || s1_ctl_reg.kind == KIND_ZERO))
        |=> (m_tdata[23:0] == 24'd0))
        else $error("port request produced nonzero rgb");
`endif

endmodule

/* rtl/plu_color_ram.sv */
// ----------------------------------------------------------------------------
// plu_color_ram
// 64-byte palette RAM, two byte banks, byte write, word read with
// registered data; per-byte valid bits give the cleared reset contents.
// ----------------------------------------------------------------------------
module plu_color_ram (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [plu_pkg::BYTE_ADDR_W-1:0]  wr_addr,
    input  logic [7:0]                       wr_data,
    input  logic                             rd_en,
    input  logic [plu_pkg::WORD_ADDR_W-1:0]  rd_addr,
    output logic [15:0]                      rd_data
);
    import plu_pkg::*;

    logic [7:0]           lo_mem [RAM_WORDS];
    logic [7:0]           hi_mem [RAM_WORDS];
    logic [RAM_BYTES-1:0] vld_reg;
    logic [7:0]           rd_lo_reg;
    logic [7:0]           rd_hi_reg;
    logic [1:0]           rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_addr[0])
        begin
            lo_mem[wr_addr[BYTE_ADDR_W-1:1]] <= wr_data;
        end
        if (wr_en && wr_addr[0])
        begin
            hi_mem[wr_addr[BYTE_ADDR_W-1:1]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_lo_reg <= lo_mem[rd_addr];
            rd_hi_reg <= hi_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= {vld_reg[{rd_addr, 1'b1}], vld_reg[{rd_addr, 1'b0}]};
            end
        end
    end

    assign rd_data = {rd_vld_reg[1] ? rd_hi_reg : 8'd0, rd_vld_reg[0] ? rd_lo_reg : 8'd0};

endmodule

/* rtl/plu_decode.sv */
// ----------------------------------------------------------------------------
// plu_decode
// Request decode: picks the result kind, shade and palette RAM word address.
// ----------------------------------------------------------------------------
module plu_decode (
    input  plu_pkg::req_t                    req,
    input  plu_pkg::cfg_t                    cfg,
    input  logic [7:0]                       bg_spec,
    input  logic [7:0]                       obj_spec,
    output plu_pkg::item_ctl_t               ctl,
    output logic [plu_pkg::WORD_ADDR_W-1:0]  rd_addr
);
    import plu_pkg::*;

    logic [7:0] map;
    logic [1:0] shade;
    logic       obj_map1;
    kind_t      blank_kind;

    assign obj_map1   = (req.pixel_palette != 3'd0);
    assign map        = (req.pixel_source == SRC_BG) ? cfg.bg_shade_map
                      : (obj_map1 ? cfg.obj_shade_map1 : cfg.obj_shade_map0);
    assign shade      = map[{req.pixel_color, 1'b0} +: 2];
    assign blank_kind = cfg.shade_output ? KIND_SHADE : KIND_WHITE;

    always_comb
    begin
        ctl     = '{kind: KIND_ZERO, shade: 2'd0, byte_hi: 1'b0, lit: 8'd0};
        rd_addr = '0;
        case (req.req_type)
            REQ_PIXEL:
            begin
                if (req.first_frame_blank || req.pixel_source == SRC_BLANK)
                begin
                    // color mode blank is white, except on a first-frame blank
                    ctl.kind = (cfg.color_mode && !req.first_frame_blank) ? KIND_WHITE
                                                                          : blank_kind;
                end
                else if (cfg.color_mode)
                begin
                    ctl.kind = (req.pixel_source == SRC_BG) ? KIND_RGB_BG : KIND_RGB_OBJ;
                    rd_addr  = {req.pixel_palette, req.pixel_color};
                end
                else if (cfg.shade_output)
                begin
                    ctl.kind  = KIND_SHADE;
                    ctl.shade = shade;
                end
                else if (req.pixel_source == SRC_BG)
                begin
                    ctl.kind = KIND_RGB_BG;
                    rd_addr  = {3'b000, shade};
                end
                else
                begin
                    ctl.kind = KIND_RGB_OBJ;
                    rd_addr  = {2'b00, obj_map1, shade};
                end
            end
            REQ_READ:
            begin
                case (req.port_select)
                    PORT_BG_SPEC:
                    begin
                        ctl.kind = KIND_LIT;
                        ctl.lit  = bg_spec | SPEC_READ_BITS;
                    end
                    PORT_BG_DATA:
                    begin
                        ctl.kind    = req.drawing ? KIND_LIT : KIND_BYTE_BG;
                        ctl.lit     = READ_BLOCKED;
                        ctl.byte_hi = bg_spec[0];
                        rd_addr     = bg_spec[BYTE_ADDR_W-1:1];
                    end
                    PORT_OBJ_SPEC:
                    begin
                        ctl.kind = KIND_LIT;
                        ctl.lit  = obj_spec | SPEC_READ_BITS;
                    end
                    default:
                    begin
                        ctl.kind    = req.drawing ? KIND_LIT : KIND_BYTE_OBJ;
                        ctl.lit     = READ_BLOCKED;
                        ctl.byte_hi = obj_spec[0];
                        rd_addr     = obj_spec[BYTE_ADDR_W-1:1];
                    end
                endcase
            end
            default:
            begin
                ctl.kind = KIND_ZERO;
            end
        endcase
    end

endmodule

/* rtl/plu_pixel_out.sv */
// ----------------------------------------------------------------------------
// plu_pixel_out
// Result formatting: rgb555 expansion, shade table, white and read byte.
// ----------------------------------------------------------------------------
module plu_pixel_out (
    input  plu_pkg::item_ctl_t  ctl,
    input  logic [15:0]         bg_word,
    input  logic [15:0]         obj_word,
    output plu_pkg::rgb_t       rgb,
    output logic [7:0]          read_data
);
    import plu_pkg::*;

    logic [15:0] word;

    assign word = (ctl.kind == KIND_RGB_BG || ctl.kind == KIND_BYTE_BG) ? bg_word : obj_word;

    always_comb
    begin
        rgb       = '0;
        read_data = 8'd0;
        case (ctl.kind)
            KIND_WHITE:
            begin
                rgb = '{blue: WHITE_LEVEL, green: WHITE_LEVEL, red: WHITE_LEVEL};
            end
            KIND_SHADE:
            begin
                rgb = shade_rgb(ctl.shade);
            end
            KIND_RGB_BG, KIND_RGB_OBJ:
            begin
                rgb.red   = expand5(word[4:0]);
                rgb.green = expand5(word[9:5]);
                rgb.blue  = expand5(word[14:10]);
            end
            KIND_BYTE_BG, KIND_BYTE_OBJ:
            begin
                read_data = ctl.byte_hi ? word[15:8] : word[7:0];
            end
            KIND_LIT:
            begin
                read_data = ctl.lit;
            end
            default:
            begin
                rgb       = '0;
                read_data = 8'd0;
            end
        endcase
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the palette lookup unit. Pixel, port write, port read
// and no-op requests go in through a queue-fed driver with random gaps, a
// monitor predicts each result from its own copy of the palette state and
// compares every returned field in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import plu_pkg::*;

    localparam logic [1:0] REQ_NOP   = 2'd3;
    localparam logic [1:0] SRC_OBJ   = 2'd2;
    localparam logic [1:0] SRC_ALIAS = 2'd3;

    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_out_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    // palette state mirror
    logic [7:0] bg_ram [64];
    logic [7:0] obj_ram [64];
    logic [7:0] bg_spec;
    logic [7:0] obj_spec;
    logic       cfg_color;
    logic       cfg_shade;
    logic [7:0] cfg_bg_map;
    logic [7:0] cfg_obj_map0;
    logic [7:0] cfg_obj_map1;

    req_t       request_q [$];
    pixel_out_t lookup_q [$];
    req_t       offer_item;
    logic       offering          = 1'b0;
    logic       req_fire          = 1'b0;
    logic       res_fire          = 1'b0;
    logic       no_idle           = 1'b0;
    logic       long_hold_pending = 1'b0;
    int         send_wait         = 0;
    int         sink_wait         = 0;
    int         sink_hold         = 0;
    int         quiet_cycles      = 0;
    int         err_count         = 0;
    int         res_count         = 0;
    int         pixel_count       = 0;
    int         write_count       = 0;
    int         read_count        = 0;
    int         other_count       = 0;
    int         cfg_writes        = 0;

    palette_lookup_rgb555_expand_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic add_request(input req_t r);
        request_q.insert(request_q.size(), r);
    endtask

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return ({3'd0, c} << 3) | ({3'd0, c} >> 2);
    endfunction

    function automatic pixel_out_t make_rgb(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pixel_out_t p;
        p = '0;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        return p;
    endfunction

    function automatic pixel_out_t green_shade(input logic [1:0] s);
        case (s)
            2'd0:    return make_rgb(8'd175, 8'd203, 8'd70);
            2'd1:    return make_rgb(8'd121, 8'd170, 8'd109);
            2'd2:    return make_rgb(8'd34, 8'd111, 8'd95);
            default: return make_rgb(8'd8, 8'd41, 8'd85);
        endcase
    endfunction

    function automatic pixel_out_t rgb555_color(input logic from_obj, input logic [5:0] addr);
        logic [5:0]  addr_hi;
        logic [15:0] word;
        addr_hi = addr + 6'd1;
        word = from_obj ? {obj_ram[addr_hi], obj_ram[addr]} : {bg_ram[addr_hi], bg_ram[addr]};
        return make_rgb(widen5(word[4:0]), widen5(word[9:5]), widen5(word[14:10]));
    endfunction

    function automatic logic [7:0] spec_advance(input logic [7:0] s);
        logic [5:0] idx;
        idx = s[5:0] + 6'd1;
        return s[SPEC_AUTO_INC] ? {2'b10, idx} : s;
    endfunction

    task automatic lookup_palette(input req_t r, output pixel_out_t res);
        pixel_out_t white;
        logic [7:0] map;
        logic [1:0] shade;
        logic       use_map1;
        white    = make_rgb(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
        use_map1 = (r.pixel_palette != 3'd0);
        res      = '0;
        case (r.req_type)
            REQ_PIXEL:
            begin
                if (r.first_frame_blank || (r.pixel_source == SRC_BLANK && !cfg_color))
                    res = cfg_shade ? green_shade(2'd0) : white;
                else if (r.pixel_source == SRC_BLANK)
                    res = white;
                else if (cfg_color)
                    res = rgb555_color(r.pixel_source != SRC_BG,
                                       {r.pixel_palette, r.pixel_color, 1'b0});
                else
                begin
                    if (r.pixel_source == SRC_BG)
                        map = cfg_bg_map;
                    else
                        map = use_map1 ? cfg_obj_map1 : cfg_obj_map0;
                    shade = map[r.pixel_color * 2 +: 2];
                    if (cfg_shade)
                        res = green_shade(shade);
                    else if (r.pixel_source == SRC_BG)
                        res = rgb555_color(1'b0, {3'd0, shade, 1'b0});
                    else
                        res = rgb555_color(1'b1, {2'd0, use_map1, shade, 1'b0});
                end
            end
            REQ_WRITE:
            begin
                case (r.port_select)
                    PORT_BG_SPEC:  bg_spec = r.write_data;
                    PORT_OBJ_SPEC: obj_spec = r.write_data;
                    PORT_BG_DATA:
                    begin
                        if (!r.drawing)
                            bg_ram[bg_spec[5:0]] = r.write_data;
                        bg_spec = spec_advance(bg_spec);
                    end
                    default:
                    begin
                        if (!r.drawing)
                            obj_ram[obj_spec[5:0]] = r.write_data;
                        obj_spec = spec_advance(obj_spec);
                    end
                endcase
            end
            REQ_READ:
            begin
                case (r.port_select)
                    PORT_BG_SPEC:  res.read_data = bg_spec | SPEC_READ_BITS;
                    PORT_OBJ_SPEC: res.read_data = obj_spec | SPEC_READ_BITS;
                    PORT_BG_DATA:
                        res.read_data = r.drawing ? READ_BLOCKED : bg_ram[bg_spec[5:0]];
                    default:
                        res.read_data = r.drawing ? READ_BLOCKED : obj_ram[obj_spec[5:0]];
                endcase
            end
            default: ;
        endcase
    endtask

    function automatic logic [23:0] pack_request(input req_t r);
        return {5'd0, r.drawing, r.write_data, r.port_select, r.first_frame_blank,
                r.pixel_color, r.pixel_palette, r.pixel_source};
    endfunction

    function automatic req_t mk_pixel(input logic [1:0] src, input logic [2:0] pal,
                                      input logic [1:0] col, input logic first);
        req_t r;
        r.req_type          = REQ_PIXEL;
        r.pixel_source      = src;
        r.pixel_palette     = pal;
        r.pixel_color       = col;
        r.first_frame_blank = first;
        r.port_select       = 2'($urandom_range(0, 3));
        r.write_data        = 8'($urandom_range(0, 255));
        r.drawing           = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic req_t mk_port(input logic [1:0] kind, input logic [1:0] port,
                                     input logic [7:0] data, input logic busy);
        req_t r;
        r.req_type          = kind;
        r.pixel_source      = 2'($urandom_range(0, 3));
        r.pixel_palette     = 3'($urandom_range(0, 7));
        r.pixel_color       = 2'($urandom_range(0, 3));
        r.first_frame_blank = 1'($urandom_range(0, 1));
        r.port_select       = port;
        r.write_data        = data;
        r.drawing           = busy;
        return r;
    endfunction

    function automatic req_t random_request();
        int         pick;
        int         src_pick;
        logic [1:0] src;
        logic [7:0] spec_val;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            src_pick = $urandom_range(0, 9);
            if (src_pick == 0)
                src = SRC_BLANK;
            else if (src_pick == 1)
                src = SRC_ALIAS;
            else if (src_pick < 6)
                src = SRC_BG;
            else
                src = SRC_OBJ;
            return mk_pixel(src, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                            $urandom_range(0, 19) == 0);
        end
        if (pick < 75)
            return mk_port(REQ_WRITE, $urandom_range(0, 1) ? PORT_OBJ_DATA : PORT_BG_DATA,
                           8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        if (pick < 80)
        begin
            spec_val = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0)
                spec_val[SPEC_AUTO_INC] = 1'b1;
            return mk_port(REQ_WRITE, $urandom_range(0, 1) ? PORT_OBJ_SPEC : PORT_BG_SPEC,
                           spec_val, 1'($urandom_range(0, 1)));
        end
        if (pick < 98)
            return mk_port(REQ_READ, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           $urandom_range(0, 7) == 0);
        return mk_port(REQ_NOP, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
    endfunction

    // auto-increment spec followed by a burst of data writes
    task automatic queue_palette_load(input logic to_obj);
        int         n;
        logic [6:0] start;
        n     = $urandom_range(4, 20);
        start = 7'($urandom_range(0, 127));
        add_request(mk_port(REQ_WRITE, to_obj ? PORT_OBJ_SPEC : PORT_BG_SPEC,
                            {1'b1, start}, 1'($urandom_range(0, 1))));
        repeat (n)
            add_request(mk_port(REQ_WRITE, to_obj ? PORT_OBJ_DATA : PORT_BG_DATA,
                                8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0));
    endtask

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return int'($urandom_range(0, 12));
        return 0;
    endfunction

    function automatic logic [7:0] pick_map();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (err_count < 30)
            $display("ERROR: %s expected %h got %h (result %0d, t=%0t)",
                     what, want, got, res_count, $realtime);
        err_count++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_COLOR_MODE:   cfg_color = val[0];
            CFG_SHADE_OUTPUT: cfg_shade = val[0];
            CFG_BG_MAP:       cfg_bg_map = val;
            CFG_OBJ_MAP0:     cfg_obj_map0 = val;
            default:          cfg_obj_map1 = val;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic color, input logic shade, input logic [7:0] bgm,
                                input logic [7:0] m0, input logic [7:0] m1);
        write_reg(CFG_COLOR_MODE, {7'd0, color});
        write_reg(CFG_SHADE_OUTPUT, {7'd0, shade});
        write_reg(CFG_BG_MAP, bgm);
        write_reg(CFG_OBJ_MAP0, m0);
        write_reg(CFG_OBJ_MAP1, m1);
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || offering || lookup_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (offering && req_fire)
                offering = 1'b0;
            if (!offering)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (request_q.size() != 0)
                begin
                    offer_item = request_q.pop_front();
                    s_tdata   <= pack_request(offer_item);
                    s_tuser   <= offer_item.req_type;
                    offering   = 1'b1;
                    send_wait  = draw_wait();
                end
            end
            s_tvalid <= offering;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (res_fire)
            sink_wait = draw_wait();
        if (long_hold_pending)
        begin
            sink_hold         = LONG_HOLD;
            long_hold_pending = 1'b0;
        end
        if (sink_hold > 0)
        begin
            sink_hold--;
            m_tready <= 1'b0;
        end
        else if (sink_wait > 0)
        begin
            sink_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // prediction and compare
    always @(posedge clk)
    begin
        pixel_out_t want;
        pixel_out_t got;
        req_fire = s_tvalid && s_tready;
        res_fire = m_tvalid && m_tready;
        if (req_fire)
        begin
            lookup_palette(offer_item, want);
            lookup_q.insert(lookup_q.size(), want);
            case (offer_item.req_type)
                REQ_PIXEL: pixel_count++;
                REQ_WRITE: write_count++;
                REQ_READ:  read_count++;
                default:   other_count++;
            endcase
        end
        if (res_fire)
        begin
            got = m_tdata;
            res_count++;
            if (lookup_q.size() == 0)
                report_mismatch("result with no request pending", '0, got);
            else
            begin
                want = lookup_q.pop_front();
                if (got.red != want.red)
                    report_mismatch("red", {24'd0, want.red}, {24'd0, got.red});
                if (got.green != want.green)
                    report_mismatch("green", {24'd0, want.green}, {24'd0, got.green});
                if (got.blue != want.blue)
                    report_mismatch("blue", {24'd0, want.blue}, {24'd0, got.blue});
                if (got.read_data != want.read_data)
                    report_mismatch("read_data", {24'd0, want.read_data},
                                    {24'd0, got.read_data});
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 64; i++)
        begin
            bg_ram[i]  = 8'd0;
            obj_ram[i] = 8'd0;
        end
        bg_spec      = 8'd0;
        obj_spec     = 8'd0;
        cfg_color    = 1'b0;
        cfg_shade    = 1'b0;
        cfg_bg_map   = 8'd0;
        cfg_obj_map0 = 8'd0;
        cfg_obj_map1 = 8'd0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // port access corners in reset config
        add_request(mk_port(REQ_READ, PORT_BG_SPEC, 8'h00, 1'b0));
        add_request(mk_port(REQ_WRITE, PORT_BG_SPEC, 8'hBE, 1'b0));
        add_request(mk_port(REQ_WRITE, PORT_BG_DATA, 8'hFF, 1'b0));
        add_request(mk_port(REQ_WRITE, PORT_BG_DATA, 8'h7F, 1'b0));
        add_request(mk_port(REQ_WRITE, PORT_BG_DATA, 8'h12, 1'b1));
        add_request(mk_port(REQ_READ, PORT_BG_DATA, 8'h00, 1'b1));
        add_request(mk_port(REQ_READ, PORT_BG_SPEC, 8'h00, 1'b1));
        add_request(mk_port(REQ_WRITE, PORT_BG_SPEC, 8'h3F, 1'b0));
        add_request(mk_port(REQ_READ, PORT_BG_DATA, 8'h00, 1'b0));
        add_request(mk_port(REQ_WRITE, PORT_OBJ_SPEC, 8'h88, 1'b0));
        add_request(mk_port(REQ_WRITE, PORT_OBJ_DATA, 8'h1F, 1'b0));
        add_request(mk_port(REQ_WRITE, PORT_OBJ_DATA, 8'h7C, 1'b0));
        add_request(mk_port(REQ_READ, PORT_OBJ_SPEC, 8'h00, 1'b0));
        add_request(mk_port(REQ_READ, PORT_OBJ_DATA, 8'h00, 1'b0));
        // mono pixels, blank, source alias, first frame, no-op
        add_request(mk_pixel(SRC_BLANK, 3'd0, 2'd0, 1'b0));
        add_request(mk_pixel(SRC_BG, 3'd7, 2'd3, 1'b0));
        add_request(mk_pixel(SRC_OBJ, 3'd5, 2'd0, 1'b0));
        add_request(mk_pixel(SRC_ALIAS, 3'd0, 2'd2, 1'b0));
        add_request(mk_pixel(SRC_OBJ, 3'd1, 2'd1, 1'b1));
        add_request(mk_port(REQ_NOP, PORT_OBJ_DATA, 8'hFF, 1'b1));
        wait_drained();

        apply_config(1'b1, 1'b1, 8'hE4, 8'h1B, 8'hFF);
        add_request(mk_pixel(SRC_BG, 3'd7, 2'd3, 1'b0));
        add_request(mk_pixel(SRC_OBJ, 3'd1, 2'd0, 1'b0));
        add_request(mk_pixel(SRC_BLANK, 3'd3, 2'd1, 1'b0));
        add_request(mk_pixel(SRC_BG, 3'd2, 2'd2, 1'b1));
        wait_drained();

        write_reg(CFG_COLOR_MODE, 8'd0);
        add_request(mk_pixel(SRC_BG, 3'd0, 2'd3, 1'b0));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // sender holds here until all results are back
            wait_drained();
            case (ph)
                0:       apply_config(1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
                1:       apply_config(1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
                default: apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      pick_map(), pick_map(), pick_map());
            endcase
            no_idle = (ph % 4 == 2);
            if (ph == 2)
                long_hold_pending = 1'b1;
            queue_palette_load(1'b0);
            queue_palette_load(1'b1);
            repeat (PHASE_ITEMS) add_request(random_request());
        end

        wait_drained();
        $display("covered %0d requests: %0d pixels, %0d port writes, %0d port reads, %0d no-ops",
                 pixel_count + write_count + read_count + other_count,
                 pixel_count, write_count, read_count, other_count);
        $display("%0d results checked, %0d register writes, one long output stall",
                 res_count, cfg_writes);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
